@@ hdl/vch_pkg.sv @@
// Shared types and constants for the video component histogram.
// Depends on nothing; used by the top level and the checker.
package vch_pkg;

   // Request kinds carried in req_tuser
   localparam logic [1:0] KIND_PIXEL = 2'd0;
   localparam logic [1:0] KIND_CLEAR = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;
   localparam logic [1:0] KIND_NONE  = 2'd3;

   // Register indexes (byte address is 4 times the index)
   localparam logic [2:0] REG_BLACK        = 3'd0;
   localparam logic [2:0] REG_WHITE        = 3'd1;
   localparam logic [2:0] REG_BLANKING     = 3'd2;
   localparam logic [2:0] REG_NTSC         = 3'd3;
   localparam logic [2:0] REG_LUMA_LOW     = 3'd4;
   localparam logic [2:0] REG_LUMA_HIGH    = 3'd5;
   localparam logic [2:0] REG_CHROMA_LOW   = 3'd6;
   localparam logic [2:0] REG_CHROMA_HIGH  = 3'd7;

   // Histogram selects
   localparam logic [2:0] HIST_Y = 3'd0;
   localparam logic [2:0] HIST_U = 3'd1;
   localparam logic [2:0] HIST_V = 3'd2;
   localparam logic [2:0] HIST_I = 3'd3;
   localparam logic [2:0] HIST_Q = 3'd4;
   localparam int         HIST_NUM = 5;

   // Fixed point: percent values in Q16, rotation constants in Q1.15
   localparam int PCT_W  = 40;   // signed percent width
   localparam int PCT_QW = 39;   // magnitude quotient width of a percent division
   localparam logic [22:0] PCT_SCALE = 23'd100;
   localparam logic signed [15:0] ROT_SIN = 16'sd17847;
   localparam logic signed [15:0] ROT_COS = 16'sd27482;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PCT_LOAD,
      ST_DIV,
      ST_ROT_MUL,
      ST_ROT_SUM,
      ST_BIN_LOAD,
      ST_UPD_RD,
      ST_UPD_WR,
      ST_RD_ADDR,
      ST_RD_DATA
   } vch_state_type;

endpackage

@@ hdl/vch_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module vch_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/video_component_histogram.sv @@
// Video component level histogram: top level with FSM, shared divider and five count RAMs.
// Depends on vch_pkg and vch_ram.
//
// Usage:
//  - req channel carries one item per transfer: a pixel (Y, U, V), a clear of all
//    histograms, or a read of one bin. req_tuser gives the kind.
//  - rsp channel returns one item (bin count, pixel total) per read, nothing for others.
//  - csr is an APB-style port for the levels, NTSC mode and the bin ranges;
//    write it only while the block is idle.
// Timing:
//  - A pixel's processing time is set by the single bit-per-cycle divider shared by
//    the three percent divisions and the five bin divisions; req_tready is low
//    meanwhile.
//  - A read goes through its address and data states; a clear sweeps all BIN_COUNT bins.
// Reset:
//  - Reset starts a clearing pass over all BIN_COUNT bins of the count RAMs; no item is
//    taken until it ends. Registers take their defaults at once.
// Stall:
//  - A result waits in the output register; new items are still taken, but a
//    following read holds in its address phase until the register frees up.
module video_component_histogram #(
   parameter int BIN_COUNT   = 256,
   parameter int COUNT_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [15:0] luma_sample, [31:16] u_sample, [47:32] v_sample,
   // [50:48] which_histogram, [58:51] bin_index, [63:59] zero
   input  logic [63:0] req_tdata,
   // [1:0] kind
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] bin_count, [63:32] pixel_total
   output logic [63:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int AW       = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
   localparam int BW       = $clog2(BIN_COUNT + 1);
   localparam int DW_BIN   = 25 + AW;
   localparam int DW       = (DW_BIN > 54) ? DW_BIN : 54;
   localparam int NUMW     = 25 + BW;
   localparam int OUT_WIDE = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;
   localparam int PW       = vch_pkg::PCT_W;
   localparam int QW       = vch_pkg::PCT_QW;
   localparam int NH       = vch_pkg::HIST_NUM;

   // ---------------------------------------------------------------- registers
   logic [15:0]       black_ff, white_ff, blank_ff;
   logic              ntsc_ff;
   logic signed [8:0] luma_lo_ff, luma_hi_ff, chroma_lo_ff, chroma_hi_ff;

   logic csr_write;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         black_ff     <= 16'd0;
         white_ff     <= 16'hFFFF;
         blank_ff     <= 16'd0;
         ntsc_ff      <= 1'b0;
         luma_lo_ff   <= -9'sd10;
         luma_hi_ff   <= 9'sd110;
         chroma_lo_ff <= -9'sd60;
         chroma_hi_ff <= 9'sd60;
      end else if (csr_write) begin
         case (csr_paddr[4:2])
            vch_pkg::REG_BLACK:       black_ff     <= csr_pwdata[15:0];
            vch_pkg::REG_WHITE:       white_ff     <= csr_pwdata[15:0];
            vch_pkg::REG_BLANKING:    blank_ff     <= csr_pwdata[15:0];
            vch_pkg::REG_NTSC:        ntsc_ff      <= csr_pwdata[0];
            vch_pkg::REG_LUMA_LOW:    luma_lo_ff   <= $signed(csr_pwdata[8:0]);
            vch_pkg::REG_LUMA_HIGH:   luma_hi_ff   <= $signed(csr_pwdata[8:0]);
            vch_pkg::REG_CHROMA_LOW:  chroma_lo_ff <= $signed(csr_pwdata[8:0]);
            vch_pkg::REG_CHROMA_HIGH: chroma_hi_ff <= $signed(csr_pwdata[8:0]);
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         vch_pkg::REG_BLACK:       csr_prdata = {16'd0, black_ff};
         vch_pkg::REG_WHITE:       csr_prdata = {16'd0, white_ff};
         vch_pkg::REG_BLANKING:    csr_prdata = {16'd0, blank_ff};
         vch_pkg::REG_NTSC:        csr_prdata = {31'd0, ntsc_ff};
         vch_pkg::REG_LUMA_LOW:    csr_prdata = {23'd0, luma_lo_ff};
         vch_pkg::REG_LUMA_HIGH:   csr_prdata = {23'd0, luma_hi_ff};
         vch_pkg::REG_CHROMA_LOW:  csr_prdata = {23'd0, chroma_lo_ff};
         vch_pkg::REG_CHROMA_HIGH: csr_prdata = {23'd0, chroma_hi_ff};
         default:                  csr_prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------- state
   vch_pkg::vch_state_type state_ff, state_in;

   logic [15:0]              y_ff;
   logic signed [15:0]       u_ff, v_ff;
   logic [2:0]               which_ff;
   logic [7:0]               rd_idx_ff;
   logic [2:0]               idx_ff;        // current percent or histogram step
   logic                     bin_phase_ff;  // divider runs bin divisions
   logic [AW-1:0]            clr_addr_ff;
   logic [COUNT_WIDTH-1:0]   pixels_ff;

   logic [DW-1:0]            div_rem_ff, div_dsh_ff;
   logic [QW-1:0]            div_q_ff;
   logic [5:0]               div_cnt_ff;
   logic                     div_neg_ff;

   logic signed [PW-1:0]     p_ff [0:NH-1];
   logic [AW-1:0]            bin_ff [0:NH-1];
   logic [NH-1:0]            ok_ff;
   logic signed [55:0]       prod_vc_ff, prod_us_ff, prod_uc_ff, prod_vs_ff;

   logic                     rsp_valid_ff;
   logic [31:0]              rsp_count_ff, rsp_total_ff;

   logic req_xfer;
   assign req_xfer = req_tvalid && req_tready;

   // ---------------------------------------------------------------- scaling
   logic signed [16:0] rdiff, uvdiff, dy;
   logic [15:0]        range16, uvrange16;

   assign rdiff     = $signed({1'b0, white_ff}) - $signed({1'b0, black_ff});
   assign uvdiff    = $signed({1'b0, white_ff}) - $signed({1'b0, blank_ff});
   assign dy        = $signed({1'b0, y_ff}) - $signed({1'b0, black_ff});
   // Hold each divisor at least 1
   assign range16   = (rdiff <= 17'sd0) ? 16'd1 : rdiff[15:0];
   assign uvrange16 = (uvdiff <= 17'sd0) ? 16'd1 : uvdiff[15:0];

   // Percent division operands for step idx_ff (Y, U, V)
   logic signed [16:0] pct_diff, pct_abs;
   logic [15:0]        pct_den;
   logic               pct_neg;
   logic [22:0]        pct_scaled;
   logic [QW-1:0]      pct_num;

   always_comb begin
      case (idx_ff)
         vch_pkg::HIST_Y: begin
            pct_diff = dy;
            pct_den  = range16;
         end
         vch_pkg::HIST_U: begin
            pct_diff = {u_ff[15], u_ff};
            pct_den  = uvrange16;
         end
         default: begin
            pct_diff = {v_ff[15], v_ff};
            pct_den  = uvrange16;
         end
      endcase
   end

   assign pct_neg    = pct_diff[16];
   assign pct_abs    = pct_neg ? -pct_diff : pct_diff;
   assign pct_scaled = 23'(pct_abs[15:0]) * vch_pkg::PCT_SCALE;
   assign pct_num    = {pct_scaled, 16'd0};

   // Bin range check and division operands for histogram idx_ff
   logic signed [PW-1:0] bp;
   logic signed [8:0]    blow, bhigh;
   logic signed [40:0]   bx, bx_mag;
   logic signed [9:0]    bspan;
   logic [24:0]          bden;
   logic                 bspan_ok, bx_neg, bsmall, bin_ok;
   logic [NUMW-1:0]      bscaled, bin_num;

   always_comb begin
      if (idx_ff == vch_pkg::HIST_Y) begin
         blow  = luma_lo_ff;
         bhigh = luma_hi_ff;
      end else begin
         blow  = chroma_lo_ff;
         bhigh = chroma_hi_ff;
      end
   end

   assign bp       = p_ff[idx_ff];
   assign bx       = $signed({bp[PW-1], bp}) - $signed({{16{blow[8]}}, blow, 16'd0});
   assign bspan    = $signed({bhigh[8], bhigh}) - $signed({blow[8], blow});
   assign bspan_ok = !bspan[9] && (bspan != 10'sd0);
   assign bden     = {bspan[8:0], 16'd0};
   assign bx_neg   = bx[40];
   assign bx_mag   = bx_neg ? -bx : bx;
   assign bsmall   = (bx_mag[40:25] == 16'd0) && (bx_mag[24:0] < bden);
   assign bscaled  = NUMW'(bx_mag[24:0]) * NUMW'(BIN_COUNT);
   // Truncation toward zero: less than one bin below low still lands in bin 0
   assign bin_ok   = bspan_ok && bsmall && (!bx_neg || (bscaled < NUMW'(bden)))
                     && ((idx_ff < vch_pkg::HIST_I) || ntsc_ff);
   assign bin_num  = bx_neg ? '0 : bscaled;

   // ---------------------------------------------------------------- divider
   logic          div_ge;
   logic [QW-1:0] div_q_next;
   assign div_ge     = div_rem_ff >= div_dsh_ff;
   assign div_q_next = {div_q_ff[QW-2:0], div_ge};

   // ---------------------------------------------------------------- rotation
   logic signed [56:0] rot_i, rot_q, rot_i_adj, rot_q_adj;
   assign rot_i     = 57'(prod_vc_ff) - 57'(prod_us_ff);
   assign rot_q     = 57'(prod_uc_ff) + 57'(prod_vs_ff);
   assign rot_i_adj = rot_i + (rot_i[56] ? 57'sd32767 : 57'sd0);
   assign rot_q_adj = rot_q + (rot_q[56] ? 57'sd32767 : 57'sd0);

   // ---------------------------------------------------------------- count RAMs
   logic [NH-1:0]          ram_wr_en;
   logic                   ram_rd_en;
   logic [AW-1:0]          ram_wr_addr [0:NH-1];
   logic [AW-1:0]          ram_rd_addr [0:NH-1];
   logic [COUNT_WIDTH-1:0] ram_wr_data [0:NH-1];
   logic [COUNT_WIDTH-1:0] ram_rd_data [0:NH-1];

   for (genvar k = 0; k < NH; k++) begin : g_ram
      vch_ram #(
         .WIDTH (COUNT_WIDTH),
         .DEPTH (BIN_COUNT)
      ) u_ram (
         .clock   (clock),
         .wr_en   (ram_wr_en[k]),
         .wr_addr (ram_wr_addr[k]),
         .wr_data (ram_wr_data[k]),
         .rd_en   (ram_rd_en),
         .rd_addr (ram_rd_addr[k]),
         .rd_data (ram_rd_data[k])
      );
   end

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
      return (c == '1) ? c : c + COUNT_WIDTH'(1);
   endfunction

   function automatic logic [31:0] clamp32(input logic [COUNT_WIDTH-1:0] c);
      logic [OUT_WIDE-1:0] w;
      w = OUT_WIDE'(c);
      return (w > OUT_WIDE'(33'h0_FFFF_FFFF)) ? 32'hFFFF_FFFF : w[31:0];
   endfunction

   // ---------------------------------------------------------------- next state
   logic clr_last, div_last, out_free;
   assign clr_last = clr_addr_ff == AW'(BIN_COUNT - 1);
   assign div_last = div_cnt_ff == 6'd0;
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         vch_pkg::ST_CLEAR: begin
            if (clr_last) state_in = vch_pkg::ST_IDLE;
         end
         vch_pkg::ST_IDLE: begin
            if (req_xfer) begin
               case (req_tuser)
                  vch_pkg::KIND_PIXEL: state_in = vch_pkg::ST_PCT_LOAD;
                  vch_pkg::KIND_CLEAR: state_in = vch_pkg::ST_CLEAR;
                  vch_pkg::KIND_READ:  state_in = vch_pkg::ST_RD_ADDR;
                  default:             state_in = vch_pkg::ST_IDLE;
               endcase
            end
         end
         vch_pkg::ST_PCT_LOAD: state_in = vch_pkg::ST_DIV;
         vch_pkg::ST_DIV: begin
            if (div_last) begin
               if (bin_phase_ff) begin
                  state_in = (idx_ff == vch_pkg::HIST_Q) ? vch_pkg::ST_UPD_RD
                                                         : vch_pkg::ST_BIN_LOAD;
               end else begin
                  state_in = (idx_ff == vch_pkg::HIST_V) ? vch_pkg::ST_ROT_MUL
                                                         : vch_pkg::ST_PCT_LOAD;
               end
            end
         end
         vch_pkg::ST_ROT_MUL:  state_in = vch_pkg::ST_ROT_SUM;
         vch_pkg::ST_ROT_SUM:  state_in = vch_pkg::ST_BIN_LOAD;
         vch_pkg::ST_BIN_LOAD: state_in = vch_pkg::ST_DIV;
         vch_pkg::ST_UPD_RD:   state_in = vch_pkg::ST_UPD_WR;
         vch_pkg::ST_UPD_WR:   state_in = vch_pkg::ST_IDLE;
         vch_pkg::ST_RD_ADDR: begin
            if (out_free) state_in = vch_pkg::ST_RD_DATA;
         end
         vch_pkg::ST_RD_DATA:  state_in = vch_pkg::ST_IDLE;
         default:              state_in = vch_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- outputs
   always_comb begin
      req_tready = state_ff == vch_pkg::ST_IDLE;
      ram_rd_en  = (state_ff == vch_pkg::ST_UPD_RD) || (state_ff == vch_pkg::ST_RD_ADDR);
      for (int k = 0; k < NH; k++) begin
         ram_wr_en[k]   = (state_ff == vch_pkg::ST_CLEAR)
                          || ((state_ff == vch_pkg::ST_UPD_WR) && ok_ff[k]);
         ram_wr_addr[k] = (state_ff == vch_pkg::ST_CLEAR) ? clr_addr_ff : bin_ff[k];
         ram_wr_data[k] = (state_ff == vch_pkg::ST_CLEAR) ? '0 : sat_inc(ram_rd_data[k]);
         ram_rd_addr[k] = (state_ff == vch_pkg::ST_RD_ADDR) ? AW'(rd_idx_ff) : bin_ff[k];
      end
   end

   // Requested bin, zero for a bad select or a bin beyond the histogram
   logic                   rd_idx_ok;
   logic [COUNT_WIDTH-1:0] rd_sel;
   assign rd_idx_ok = {24'd0, rd_idx_ff} < 32'(BIN_COUNT);

   always_comb begin
      case (which_ff)
         vch_pkg::HIST_Y: rd_sel = ram_rd_data[0];
         vch_pkg::HIST_U: rd_sel = ram_rd_data[1];
         vch_pkg::HIST_V: rd_sel = ram_rd_data[2];
         vch_pkg::HIST_I: rd_sel = ram_rd_data[3];
         vch_pkg::HIST_Q: rd_sel = ram_rd_data[4];
         default:         rd_sel = '0;
      endcase
   end

   // ---------------------------------------------------------------- control regs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vch_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         pixels_ff    <= '0;
         idx_ff       <= 3'd0;
         bin_phase_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;

         // Sweep the RAMs one entry a cycle
         if (state_ff == vch_pkg::ST_CLEAR) begin
            clr_addr_ff <= clr_last ? '0 : clr_addr_ff + AW'(1);
         end

         if (req_xfer && (req_tuser == vch_pkg::KIND_CLEAR)) begin
            pixels_ff <= '0;
         end else if (state_ff == vch_pkg::ST_UPD_WR) begin
            pixels_ff <= sat_inc(pixels_ff);
         end

         if (req_xfer) begin
            idx_ff       <= 3'd0;
            bin_phase_ff <= 1'b0;
         end else if (state_ff == vch_pkg::ST_ROT_SUM) begin
            idx_ff       <= 3'd0;
            bin_phase_ff <= 1'b1;
         end else if ((state_ff == vch_pkg::ST_DIV) && div_last) begin
            idx_ff <= idx_ff + 3'd1;
         end

         if (state_ff == vch_pkg::ST_RD_DATA) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- datapath regs
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         y_ff      <= req_tdata[15:0];
         u_ff      <= $signed(req_tdata[31:16]);
         v_ff      <= $signed(req_tdata[47:32]);
         which_ff  <= req_tdata[50:48];
         rd_idx_ff <= req_tdata[58:51];
      end

      case (state_ff)
         vch_pkg::ST_PCT_LOAD: begin
            div_rem_ff <= DW'(pct_num);
            div_dsh_ff <= DW'(pct_den) << (QW - 1);
            div_q_ff   <= '0;
            div_cnt_ff <= 6'(QW - 1);
            div_neg_ff <= pct_neg;
         end
         vch_pkg::ST_BIN_LOAD: begin
            div_rem_ff     <= DW'(bin_num);
            div_dsh_ff     <= DW'(bden) << (AW - 1);
            div_q_ff       <= '0;
            div_cnt_ff     <= 6'(AW - 1);
            div_neg_ff     <= 1'b0;
            ok_ff[idx_ff]  <= bin_ok;
         end
         vch_pkg::ST_DIV: begin
            // One quotient bit a cycle, restoring
            if (div_ge) div_rem_ff <= div_rem_ff - div_dsh_ff;
            div_dsh_ff <= div_dsh_ff >> 1;
            div_q_ff   <= div_q_next;
            div_cnt_ff <= div_cnt_ff - 6'd1;
            if (div_last) begin
               if (bin_phase_ff) begin
                  bin_ff[idx_ff] <= div_q_next[AW-1:0];
               end else begin
                  p_ff[idx_ff] <= div_neg_ff ? -$signed({1'b0, div_q_next})
                                             : $signed({1'b0, div_q_next});
               end
            end
         end
         vch_pkg::ST_ROT_MUL: begin
            prod_vc_ff <= 56'(p_ff[2]) * 56'(vch_pkg::ROT_COS);
            prod_us_ff <= 56'(p_ff[1]) * 56'(vch_pkg::ROT_SIN);
            prod_uc_ff <= 56'(p_ff[1]) * 56'(vch_pkg::ROT_COS);
            prod_vs_ff <= 56'(p_ff[2]) * 56'(vch_pkg::ROT_SIN);
         end
         vch_pkg::ST_ROT_SUM: begin
            // Divide by 2^15 truncating toward zero
            p_ff[3] <= rot_i_adj[PW+14:15];
            p_ff[4] <= rot_q_adj[PW+14:15];
         end
         vch_pkg::ST_RD_DATA: begin
            rsp_count_ff <= clamp32(rd_idx_ok ? rd_sel : '0);
            rsp_total_ff <= clamp32(pixels_ff);
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_total_ff, rsp_count_ff};

endmodule

@@ hdl/vch_checker.sv @@
// Port-level checker for the video component histogram, bound to the top level.
// Depends on vch_pkg.
module vch_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [63:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        csr_psel,
   input logic        csr_penable,
   input logic        csr_pwrite,
   input logic [4:0]  csr_paddr,
   input logic [31:0] csr_pwdata,
   input logic [31:0] csr_prdata,
   input logic        csr_pready
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("stalled result changed");

   // An accepted pixel makes the block busy and drops req_tready
   a_pixel_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == vch_pkg::KIND_PIXEL) |=> !req_tready)
      else $error("pixel did not occupy the block");

   // A read needs its RAM access before any result appears
   a_read_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == vch_pkg::KIND_READ) && !rsp_tvalid
      |=> !rsp_tvalid)
      else $error("read result appeared too early");

endmodule

bind video_component_histogram vch_checker u_vch_checker (.*);
